@@ rtl/core/cprs_pkg.sv @@
// Shared types and constants of the count pair range sum engine.
`timescale 1ns / 1ps
`default_nettype none

package cprs_pkg;

   // Fixed field widths
   localparam int TYPE_W  = 2;
   localparam int INDEX_W = 16;
   localparam int POS_W   = 17;
   localparam int COUNT_W = 16;
   localparam int ENTRY_W = 2 * COUNT_W;
   localparam int TOTAL_W = 32;
   localparam int COVER_W = 17;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 88;

   // Request codes carried on req_tuser
   localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WB,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Accumulator control from the sequencer
   typedef struct packed {
      logic clear;
      logic add;
   } acc_ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/count_pair_range_sum_engine_unit.sv @@
// Top level of the count pair range sum engine: stream ports and result register.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a table of TABLE_DEPTH count pairs (methylated low half, unmethylated
// high half) in one synchronous RAM with a registered read.
// Request channel req_*: req_tuser selects write, add or range query.
//   write: the entry is stored at the accept edge.
//   add:   read at accept, sum written back the next cycle.
//   query: the stop is clamped to TABLE_DEPTH; the walk reads one entry per
//          cycle from the RAM port. An empty or inverted range skips the
//          walk and returns zeros.
// Writes and adds (and out-of-range or unused codes) give no result item.
// Response channel rsp_*: one item per query, held in an output register.
// While a result waits for rsp_tready, writes and adds still proceed; the
// next query walks its range and waits at its end for the register to free.
// Reset clears the sequencer and the result valid; table contents stay
// undefined and entries must be written before they are read.
module count_pair_range_sum_engine_unit
   import cprs_pkg::*;
#(
   parameter int TABLE_DEPTH = 65536
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [15:0] entry_index, [32:16] range_start, [49:33] range_stop,
   // [65:50] meth_count, [81:66] unmeth_count, [87:82] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  wire logic [TYPE_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [31:0] meth_total, [63:32] unmeth_total, [80:64] covered_total, [87:81] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CMP_W  = (ADDR_W + 1 > POS_W) ? ADDR_W + 1 : POS_W;

   // Unpacked request fields
   logic [INDEX_W-1:0] entry_index;
   logic [POS_W-1:0]   range_start;
   logic [POS_W-1:0]   range_stop;
   logic [COUNT_W-1:0] meth_count;
   logic [COUNT_W-1:0] unmeth_count;

   assign entry_index  = req_tdata[15:0];
   assign range_start  = req_tdata[32:16];
   assign range_stop   = req_tdata[49:33];
   assign meth_count   = req_tdata[65:50];
   assign unmeth_count = req_tdata[81:66];

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;
   acc_ctl_type        acc_ctl;
   logic               res_push;
   logic               out_free;
   logic [TOTAL_W-1:0] meth_total;
   logic [TOTAL_W-1:0] unmeth_total;
   logic [COVER_W-1:0] covered_total;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0]    rsp_meth_ff, rsp_meth_in;
   logic [TOTAL_W-1:0]    rsp_unmeth_ff, rsp_unmeth_in;
   logic [COVER_W-1:0]    rsp_cover_ff, rsp_cover_in;

   assign out_free = !rsp_valid_ff || rsp_tready;

   cprs_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W),
      .CMP_W       (CMP_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_type     (req_tuser),
      .entry_index  (entry_index),
      .range_start  (range_start),
      .range_stop   (range_stop),
      .meth_count   (meth_count),
      .unmeth_count (unmeth_count),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .acc_ctl      (acc_ctl),
      .res_push     (res_push),
      .out_free     (out_free)
   );

   cprs_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_table (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   cprs_accum u_accum (
      .clock         (clock),
      .acc_ctl       (acc_ctl),
      .entry_data    (mem_rdata),
      .meth_total    (meth_total),
      .unmeth_total  (unmeth_total),
      .covered_total (covered_total)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_meth_in   = rsp_meth_ff;
      rsp_unmeth_in = rsp_unmeth_ff;
      rsp_cover_in  = rsp_cover_ff;
      if (res_push) begin
         rsp_valid_in  = 1'b1;
         rsp_meth_in   = meth_total;
         rsp_unmeth_in = unmeth_total;
         rsp_cover_in  = covered_total;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_meth_ff   <= rsp_meth_in;
      rsp_unmeth_ff <= rsp_unmeth_in;
      rsp_cover_ff  <= rsp_cover_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_cover_ff, rsp_unmeth_ff, rsp_meth_ff};

   // A result is only loaded when the register is empty or draining
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      res_push |-> out_free)
      else $error("result pushed into an occupied register");

   // A query leaves the sequencer busy after acceptance
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == REQ_QUERY) |=> !req_tready)
      else $error("request taken while a query is in flight");

   // A range never covers more than 65536 entries
   a_cover_bound: assert property (@(posedge clock) disable iff (reset)
      res_push |=> (rsp_cover_ff <= COVER_W'(65536)))
      else $error("covered count out of range");

   // A loaded result is valid in the next cycle
   a_push_valid: assert property (@(posedge clock) disable iff (reset)
      res_push |=> rsp_valid_ff)
      else $error("pushed result not presented");

endmodule

`default_nettype wire

@@ rtl/core/cprs_table.sv @@
// Count table: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cprs_table
   import cprs_pkg::*;
#(
   parameter int TABLE_DEPTH = 65536,
   parameter int ADDR_W      = 16
) (
   input  wire logic               clock,
   input  wire logic               mem_we,
   input  wire logic [ADDR_W-1:0]  mem_waddr,
   input  wire logic [ENTRY_W-1:0] mem_wdata,
   input  wire logic               mem_re,
   input  wire logic [ADDR_W-1:0]  mem_raddr,
   output logic      [ENTRY_W-1:0] mem_rdata
);

   logic [ENTRY_W-1:0] store_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= store_mem[mem_raddr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/core/cprs_accum.sv @@
// Range accumulators: methylated sum, unmethylated sum, covered entry count.
`timescale 1ns / 1ps
`default_nettype none

module cprs_accum
   import cprs_pkg::*;
(
   input  wire logic               clock,
   input  wire acc_ctl_type        acc_ctl,
   input  wire logic [ENTRY_W-1:0] entry_data,
   output logic      [TOTAL_W-1:0] meth_total,
   output logic      [TOTAL_W-1:0] unmeth_total,
   output logic      [COVER_W-1:0] covered_total
);

   logic [TOTAL_W-1:0] meth_ff, meth_in;
   logic [TOTAL_W-1:0] unmeth_ff, unmeth_in;
   logic [COVER_W-1:0] cover_ff, cover_in;

   always_comb begin
      meth_in   = meth_ff;
      unmeth_in = unmeth_ff;
      cover_in  = cover_ff;
      if (acc_ctl.clear) begin
         meth_in   = '0;
         unmeth_in = '0;
         cover_in  = '0;
      end else if (acc_ctl.add) begin
         meth_in   = meth_ff + TOTAL_W'(entry_data[COUNT_W-1:0]);
         unmeth_in = unmeth_ff + TOTAL_W'(entry_data[ENTRY_W-1:COUNT_W]);
         cover_in  = cover_ff + COVER_W'(entry_data != '0);
      end
   end

   always_ff @(posedge clock) begin
      meth_ff   <= meth_in;
      unmeth_ff <= unmeth_in;
      cover_ff  <= cover_in;
   end

   assign meth_total    = meth_ff;
   assign unmeth_total  = unmeth_ff;
   assign covered_total = cover_ff;

endmodule

`default_nettype wire

@@ rtl/core/cprs_ctrl.sv @@
// Request sequencer: table writes, read-modify-write adds and range walks.
`timescale 1ns / 1ps
`default_nettype none

module cprs_ctrl
   import cprs_pkg::*;
#(
   parameter int TABLE_DEPTH = 65536,
   parameter int ADDR_W      = 16,
   parameter int CMP_W       = 17
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [TYPE_W-1:0]  req_type,
   input  wire logic [INDEX_W-1:0] entry_index,
   input  wire logic [POS_W-1:0]   range_start,
   input  wire logic [POS_W-1:0]   range_stop,
   input  wire logic [COUNT_W-1:0] meth_count,
   input  wire logic [COUNT_W-1:0] unmeth_count,
   output logic                    mem_we,
   output logic [ADDR_W-1:0]       mem_waddr,
   output logic [ENTRY_W-1:0]      mem_wdata,
   output logic                    mem_re,
   output logic [ADDR_W-1:0]       mem_raddr,
   input  wire logic [ENTRY_W-1:0] mem_rdata,
   output acc_ctl_type             acc_ctl,
   output logic                    res_push,
   input  wire logic               out_free
);

   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

   state_type state_ff, state_in;

   logic [CMP_W-1:0]   cur_ff, cur_in;
   logic [CMP_W-1:0]   stop_ff, stop_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0] meth_ff, meth_in;
   logic [COUNT_W-1:0] unmeth_ff, unmeth_in;
   logic               rd_pending_ff, rd_pending_in;

   logic               accept;
   logic               idx_ok;
   logic [CMP_W-1:0]   start_ext;
   logic [CMP_W-1:0]   stop_ext;
   logic [CMP_W-1:0]   stop_clamp;
   logic [CMP_W-1:0]   cur_next;
   logic               range_empty;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign idx_ok      = CMP_W'(entry_index) < DEPTH_C;
   assign start_ext   = CMP_W'(range_start);
   assign stop_ext    = CMP_W'(range_stop);
   assign stop_clamp  = (stop_ext > DEPTH_C) ? DEPTH_C : stop_ext;
   assign range_empty = !(start_ext < stop_clamp);
   assign cur_next    = cur_ff + CMP_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == REQ_ADD && idx_ok) begin
               state_in = ST_ADD_WB;
            end else if (accept && req_type == REQ_QUERY) begin
               state_in = range_empty ? ST_FINISH : ST_WALK;
            end
         end
         ST_ADD_WB: state_in = ST_IDLE;
         ST_WALK: begin
            if (cur_next == stop_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath registers
   always_comb begin
      cur_in        = cur_ff;
      stop_in       = stop_ff;
      idx_in        = idx_ff;
      meth_in       = meth_ff;
      unmeth_in     = unmeth_ff;
      rd_pending_in = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = ADDR_W'(entry_index);
      mem_wdata     = {unmeth_count, meth_count};
      mem_re        = 1'b0;
      mem_raddr     = ADDR_W'(entry_index);
      acc_ctl       = '0;
      res_push      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_WRITE: mem_we = idx_ok;
                  REQ_ADD: begin
                     mem_re    = idx_ok;
                     idx_in    = ADDR_W'(entry_index);
                     meth_in   = meth_count;
                     unmeth_in = unmeth_count;
                  end
                  REQ_QUERY: begin
                     acc_ctl.clear = 1'b1;
                     cur_in        = start_ext;
                     stop_in       = stop_clamp;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD_WB: begin
            // Read data of the entry arrived this cycle; halves wrap at 16 bits
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = {mem_rdata[ENTRY_W-1:COUNT_W] + unmeth_ff,
                         mem_rdata[COUNT_W-1:0] + meth_ff};
         end
         ST_WALK: begin
            mem_re        = 1'b1;
            mem_raddr     = cur_ff[ADDR_W-1:0];
            cur_in        = cur_next;
            rd_pending_in = 1'b1;
            acc_ctl.add   = rd_pending_ff;
         end
         ST_DRAIN: begin
            acc_ctl.add = rd_pending_ff;
         end
         ST_FINISH: begin
            res_push = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_pending_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pending_ff <= rd_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      stop_ff   <= stop_in;
      idx_ff    <= idx_in;
      meth_ff   <= meth_in;
      unmeth_ff <= unmeth_in;
   end

endmodule

`default_nettype wire

@@ sim/count_pair_range_sum_engine_unit_tb.sv @@
// Self-checking testbench for the count pair range sum engine.
`timescale 1ns / 1ps

module count_pair_range_sum_engine_unit_tb;
   import cprs_pkg::*;

   localparam int unsigned DEPTH          = 65536;
   localparam int          CLK_PERIOD     = 12;
   localparam int          WIN_SPAN       = 64;      // entries per preloaded window
   localparam int          ITEM_TARGET    = 1050;    // random items, window preload included
   localparam int          LONG_HOLD      = 200;     // receiver hold-off, cycles
   localparam int          SETTLE_CYCLES  = 40;
   localparam int          WATCHDOG_LIMIT = 3000;    // cycles with no item accepted
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [TYPE_W-1:0]  kind;
      logic [INDEX_W-1:0] index;
      logic [POS_W-1:0]   start;
      logic [POS_W-1:0]   stop;
      logic [COUNT_W-1:0] meth;
      logic [COUNT_W-1:0] unmeth;
   } count_req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] meth_total;
      logic [TOTAL_W-1:0] unmeth_total;
      logic [COVER_W-1:0] covered_total;
   } tally_type;

   typedef struct packed {
      count_req_type req;
      bit            typed;    // totals below are fixed by hand
      tally_type     totals;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [TYPE_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Predictor copy of the table, methylated count in the low half.
   logic [ENTRY_W-1:0]    pair_mem [DEPTH];
   tally_type             expected_totals [$];
   logic [INDEX_W-1:0]    loose_entries [$];   // written anywhere in the table
   dir_row_type           dir_plan [$];

   bit                    row_typed;
   tally_type             row_totals;
   bit                    rsp_hold_req;
   int                    req_quiet_left;
   int unsigned           fault_count;
   int unsigned           quiet_cycles;

   count_pair_range_sum_engine_unit #(
      .TABLE_DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Apply one request to the table copy; a query yields its totals.
   task automatic apply_count_req(input count_req_type it, output bit has,
                                  output tally_type t);
      int unsigned        hi;
      logic [INDEX_W-1:0] addr;
      logic [ENTRY_W-1:0] e;
      logic [COUNT_W-1:0] m_sum;
      logic [COUNT_W-1:0] u_sum;
      has = 1'b0;
      t   = '0;
      case (it.kind)
         REQ_WRITE: begin
            pair_mem[it.index] = {it.unmeth, it.meth};
         end
         REQ_ADD: begin
            e     = pair_mem[it.index];
            m_sum = e[COUNT_W-1:0] + it.meth;
            u_sum = e[ENTRY_W-1:COUNT_W] + it.unmeth;
            pair_mem[it.index] = {u_sum, m_sum};
         end
         REQ_QUERY: begin
            has = 1'b1;
            hi  = (it.stop > DEPTH) ? DEPTH : it.stop;
            for (int unsigned i = it.start; i < hi; i++) begin
               addr = INDEX_W'(i);
               e    = pair_mem[addr];
               t.meth_total    += TOTAL_W'(e[COUNT_W-1:0]);
               t.unmeth_total  += TOTAL_W'(e[ENTRY_W-1:COUNT_W]);
               t.covered_total += COVER_W'(e != '0);
            end
         end
         default: ;
      endcase
   endtask

   function automatic dir_row_type mk_row(logic [TYPE_W-1:0] kind, int unsigned idx,
                                          int unsigned start, int unsigned stop,
                                          int unsigned meth, int unsigned unmeth, bit typed,
                                          longint unsigned m_tot, longint unsigned u_tot,
                                          int unsigned cov);
      dir_row_type r;
      r.req.kind   = kind;
      r.req.index  = INDEX_W'(idx);
      r.req.start  = POS_W'(start);
      r.req.stop   = POS_W'(stop);
      r.req.meth   = COUNT_W'(meth);
      r.req.unmeth = COUNT_W'(unmeth);
      r.typed      = typed;
      r.totals.meth_total    = TOTAL_W'(m_tot);
      r.totals.unmeth_total  = TOTAL_W'(u_tot);
      r.totals.covered_total = COVER_W'(cov);
      return r;
   endfunction

   function automatic int unsigned window_base(int w);
      case (w)
         0:       return 0;
         1:       return 'h5A40;
         2:       return 'hA5C0;
         default: return DEPTH - WIN_SPAN;   // last window, reaches the table end
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] rand_count();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return COUNT_W'($urandom);
      endcase
   endfunction

   // Sender gap per item, with occasional runs of back-to-back items.
   function automatic int sender_gap();
      if (req_quiet_left > 0) begin
         req_quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) req_quiet_left = $urandom_range(8, 40);
      return $urandom_range(0, 7);
   endfunction

   // Random request, mostly over the preloaded windows so queries and adds
   // only touch written entries.
   task automatic plan_random_req(output count_req_type it, output bit counts);
      int          pick;
      int          w;
      int unsigned base;
      int unsigned s;
      int unsigned e;
      pick      = $urandom_range(0, 99);
      w         = $urandom_range(0, 3);
      base      = window_base(w);
      counts    = 1'b1;
      it.index  = INDEX_W'($urandom);
      it.start  = POS_W'($urandom);
      it.stop   = POS_W'($urandom);
      it.meth   = rand_count();
      it.unmeth = rand_count();
      if ($urandom_range(0, 6) == 0) begin
         it.meth   = '0;
         it.unmeth = '0;
      end
      if (pick < 35) begin
         it.kind = REQ_QUERY;
         s = base + $urandom_range(0, WIN_SPAN - 1);
         e = s + (($urandom_range(0, 9) == 0) ? $urandom_range(21, WIN_SPAN)
                                               : $urandom_range(0, 20));
         if (e > base + WIN_SPAN) e = base + WIN_SPAN;
         // last window: stop past the table gets clamped
         if (w == 3 && $urandom_range(0, 2) == 0) e = $urandom_range(DEPTH, 2 * DEPTH - 1);
         it.start = POS_W'(s);
         it.stop  = POS_W'(e);
      end else if (pick < 45) begin
         // empty or inverted range, nothing read
         it.kind = REQ_QUERY;
         if ($urandom_range(0, 1) == 0) begin
            s = $urandom_range(0, 2 * DEPTH - 1);
            it.start = POS_W'(s);
            it.stop  = POS_W'($urandom_range(0, s));
         end else begin
            it.start = POS_W'($urandom_range(DEPTH, 2 * DEPTH - 1));
         end
      end else if (pick < 65) begin
         it.kind  = REQ_WRITE;
         it.index = INDEX_W'(base + $urandom_range(0, WIN_SPAN - 1));
      end else if (pick < 80) begin
         it.kind = REQ_ADD;
         if (loose_entries.size() != 0 && $urandom_range(0, 2) == 0)
            it.index = loose_entries[$urandom_range(0, loose_entries.size() - 1)];
         else
            it.index = INDEX_W'(base + $urandom_range(0, WIN_SPAN - 1));
      end else if (pick < 95) begin
         it.kind = REQ_WRITE;   // anywhere in the table
         loose_entries.push_back(it.index);
      end else begin
         it.kind = REQ_UNUSED;
         counts  = 1'b0;
      end
   endtask

   task automatic send_req(input count_req_type it, input int gap, input bit typed,
                           input tally_type totals);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      row_typed   = typed;
      row_totals  = totals;
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {{(REQ_DATA_W - 82){1'b0}}, it.unmeth, it.meth, it.stop, it.start,
                     it.index};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Sender stops until every pending query has answered.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_totals.size() != 0);
   endtask

   // Sender side: reset, directed table, window preload, random items.
   initial begin : req_side
      count_req_type it;
      bit            counts;
      int unsigned   sent;
      int unsigned   ops;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = REQ_WRITE;
      row_typed      = 1'b0;
      row_totals     = '0;
      rsp_hold_req   = 1'b0;
      req_quiet_left = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // kind, index, start, stop, meth, unmeth, typed, meth/unmeth/covered totals
      dir_plan.push_back(mk_row(REQ_WRITE, 0, 0, 0, 'hFFFF, 'hFFFF, 0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_WRITE, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_WRITE, 2, 0, 0, 1, 0, 0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_WRITE, 3, 0, 0, 0, 1, 0, 0, 0, 0));
      // one zero pair among four, sums carry past 16 bits
      dir_plan.push_back(mk_row(REQ_QUERY, 0, 0, 4, 0, 0, 1, 'h10000, 'h10000, 3));
      // add wraps both halves of entry 0 back to a zero pair
      dir_plan.push_back(mk_row(REQ_ADD, 0, 0, 0, 1, 1, 0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_QUERY, 0, 0, 1, 0, 0, 1, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_ADD, 2, 0, 0, 'hFFFF, 2, 0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_WRITE, 'hFFFF, 0, 0, 'h1234, 'h5678, 0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_WRITE, 'hFFFE, 0, 0, 'h8000, 'h0001, 0, 0, 0, 0));
      // stop past the table is clamped
      dir_plan.push_back(mk_row(REQ_QUERY, 0, 'hFFFE, 'h1FFFF, 0, 0, 1, 'h9234, 'h5679, 2));
      // start at the table end: empty after clamping
      dir_plan.push_back(mk_row(REQ_QUERY, 0, 'h10000, 'h1FFFF, 0, 0, 1, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_QUERY, 0, 5, 3, 0, 0, 1, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_QUERY, 0, 2, 2, 0, 0, 1, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_UNUSED, 'hFFFF, 'h1FFFF, 'h1FFFF, 'hFFFF, 'hFFFF,
                                0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_QUERY, 'hFFFF, 'h1FFFF, 0, 'hFFFF, 'hFFFF,
                                1, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_QUERY, 0, 1, 4, 0, 0, 0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_ADD, 'hFFFF, 0, 0, 'hFFFF, 'hFFFF, 0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_QUERY, 0, 'hFFFE, 'h10000, 0, 0, 0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_WRITE, 'h8000, 0, 0, 0, 0, 0, 0, 0, 0));
      dir_plan.push_back(mk_row(REQ_QUERY, 0, 'hFFFC, 'hFFFC, 0, 0, 1, 0, 0, 0));
      foreach (dir_plan[i])
         send_req(dir_plan[i].req, sender_gap(), dir_plan[i].typed, dir_plan[i].totals);

      // Preload the query windows so every query below reads written entries.
      sent = 0;
      for (int w = 0; w < 4; w++) begin
         for (int i = 0; i < WIN_SPAN; i++) begin
            it        = '0;
            it.kind   = REQ_WRITE;
            it.index  = INDEX_W'(window_base(w) + i);
            it.start  = POS_W'($urandom);
            it.stop   = POS_W'($urandom);
            it.meth   = rand_count();
            it.unmeth = rand_count();
            send_req(it, sender_gap(), 1'b0, '0);
            sent++;
         end
      end

      ops = 0;
      while (sent < ITEM_TARGET) begin
         if (ops == 300) begin
            // receiver stalls long while items keep coming back to back
            rsp_hold_req   = 1'b1;
            req_quiet_left = 60;
         end
         if (ops == 600) wait_drained();
         plan_random_req(it, counts);
         send_req(it, sender_gap(), 1'b0, '0);
         ops++;
         if (counts) sent++;
      end
      req_tvalid <= 1'b0;

      while (expected_totals.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("PASS count_pair_range_sum_engine_unit");
      else
         $display("FAIL count_pair_range_sum_engine_unit");
      $finish;
   end

   // Receiver side: random stalls per result, one long hold on request.
   initial begin : rsp_side
      int gap;
      int served;
      bit quiet;
      rsp_tready = 1'b0;
      served     = 0;
      quiet      = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (served % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (rsp_hold_req) begin
            gap          = LONG_HOLD;
            rsp_hold_req = 1'b0;
         end else begin
            gap = quiet ? 0 : $urandom_range(0, 7);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         served++;
         @(negedge clock);
      end
   end

   // Predict on request accept, compare on response accept, watchdog.
   always @(posedge clock) begin : scoreboard
      count_req_type seen;
      tally_type     predicted;
      tally_type     want;
      tally_type     got;
      bit            has;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.kind   = req_tuser;
            seen.index  = req_tdata[15:0];
            seen.start  = req_tdata[32:16];
            seen.stop   = req_tdata[49:33];
            seen.meth   = req_tdata[65:50];
            seen.unmeth = req_tdata[81:66];
            apply_count_req(seen, has, predicted);
            if (has) expected_totals.push_back(row_typed ? row_totals : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.meth_total    = rsp_tdata[31:0];
            got.unmeth_total  = rsp_tdata[63:32];
            got.covered_total = rsp_tdata[80:64];
            if (expected_totals.size() == 0) begin
               $error("unexpected result item: meth_total %0h unmeth_total %0h covered_total %0h",
                      got.meth_total, got.unmeth_total, got.covered_total);
               fault_count++;
            end else begin
               want = expected_totals.pop_front();
               if (got.meth_total !== want.meth_total) begin
                  $error("meth_total: expected %0h, actual %0h",
                         want.meth_total, got.meth_total);
                  fault_count++;
               end
               if (got.unmeth_total !== want.unmeth_total) begin
                  $error("unmeth_total: expected %0h, actual %0h",
                         want.unmeth_total, got.unmeth_total);
                  fault_count++;
               end
               if (got.covered_total !== want.covered_total) begin
                  $error("covered_total: expected %0h, actual %0h",
                         want.covered_total, got.covered_total);
                  fault_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL count_pair_range_sum_engine_unit");
            $finish;
         end
      end
   end

endmodule
